### hdl/hkta_pkg.sv
`default_nettype none

package hkta_pkg;

	// Ring buffer geometry. One slot is kept free, so at most DEPTH-1 characters are held.
	localparam int DEPTH = 32;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CHAR_W = 7;

	// Item kinds.
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Shift positions in the HID modifier byte.
	localparam int SHIFT_L_BIT = 1;
	localparam int SHIFT_R_BIT = 5;

	// The offset between lower and upper case letters.
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DONE
	} hkta_state_t;

	typedef struct packed {
		logic start_key;
		logic start_read;
		logic finish_read;
	} hkta_cmd_t;

	// Advance a ring pointer, wrapping from DEPTH-1 back to zero.
	function automatic ptr_t next_ptr(input ptr_t p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// German keyboard layout, unshifted. Zero means the code has no character.
	function automatic char_t layout_lookup(input logic [7:0] code);
		char_t c;
		unique case (code)
			8'h14: c = 7'h71; // q
			8'h1a: c = 7'h77; // w
			8'h08: c = 7'h65; // e
			8'h15: c = 7'h72; // r
			8'h17: c = 7'h74; // t
			8'h1c: c = 7'h7a; // z
			8'h18: c = 7'h75; // u
			8'h0c: c = 7'h69; // i
			8'h12: c = 7'h6f; // o
			8'h13: c = 7'h70; // p
			8'h04: c = 7'h61; // a
			8'h16: c = 7'h73; // s
			8'h07: c = 7'h64; // d
			8'h09: c = 7'h66; // f
			8'h0a: c = 7'h67; // g
			8'h0b: c = 7'h68; // h
			8'h0d: c = 7'h6a; // j
			8'h0e: c = 7'h6b; // k
			8'h0f: c = 7'h6c; // l
			8'h1d: c = 7'h79; // y
			8'h1b: c = 7'h78; // x
			8'h06: c = 7'h63; // c
			8'h19: c = 7'h76; // v
			8'h05: c = 7'h62; // b
			8'h11: c = 7'h6e; // n
			8'h10: c = 7'h6d; // m
			8'h2c: c = 7'h20; // space
			8'h62: c = 7'h30; // keypad digits
			8'h59: c = 7'h31;
			8'h5a: c = 7'h32;
			8'h5b: c = 7'h33;
			8'h5c: c = 7'h34;
			8'h5d: c = 7'h35;
			8'h5e: c = 7'h36;
			8'h5f: c = 7'h37;
			8'h60: c = 7'h38;
			8'h61: c = 7'h39;
			8'h54: c = 7'h2f; // keypad slash
			8'h55: c = 7'h2a; // keypad star
			8'h56: c = 7'h2d; // keypad minus
			8'h57: c = 7'h2b; // keypad plus
			8'h1e: c = 7'h21; // top row, printed as shifted symbols
			8'h1f: c = 7'h22;
			8'h21: c = 7'h24;
			8'h22: c = 7'h25;
			8'h23: c = 7'h26;
			8'h24: c = 7'h2f;
			8'h25: c = 7'h28;
			8'h26: c = 7'h29;
			8'h27: c = 7'h3d;
			8'h2d: c = 7'h3f;
			8'h2e: c = 7'h27; // apostrophe
			8'h38: c = 7'h2d; // minus
			8'h2a: c = 7'h08; // backspace
			8'h37: c = 7'h2e; // period
			8'h63: c = 7'h2e; // keypad period
			8'h58: c = 7'h0a; // keypad enter
			8'h28: c = 7'h0a; // enter
			8'h29: c = 7'h1b; // escape
			8'h41: c = 7'h07; // bell
			default: c = '0;
		endcase
		return c;
	endfunction

	// Either shift key turns letters to upper case and minus to underscore.
	function automatic char_t apply_shift(input logic [7:0] mods, input char_t c);
		char_t r;
		r = c;
		if (mods[SHIFT_L_BIT] || mods[SHIFT_R_BIT]) begin
			if (c >= 7'h61 && c <= 7'h7a) begin
				r = c - CASE_OFFSET;
			end else if (c == 7'h2d) begin
				r = 7'h5f;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/hkta_ram.sv
`default_nettype none

module hkta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/hkta_ctrl.sv
`default_nettype none

module hkta_ctrl
	import hkta_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic operation,
	input  wire logic rsp_ready,
	output logic      req_ready,
	output logic      rsp_valid,
	output hkta_cmd_t cmd
);

	hkta_state_t state_q, state_d;
	logic        accept;

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (operation == OP_READ) ? ST_READ : ST_DONE;
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_DONE: begin
				if (accept) begin
					state_d = (operation == OP_READ) ? ST_READ : ST_DONE;
				end else if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready        = 1'b0;
		rsp_valid        = 1'b0;
		cmd.finish_read  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_READ: cmd.finish_read = 1'b1;
			ST_DONE: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
			end
			default: ;
		endcase
		cmd.start_key  = req_valid && req_ready && (operation == OP_KEY);
		cmd.start_read = req_valid && req_ready && (operation == OP_READ);
	end

endmodule

`default_nettype wire

### hdl/hkta_datapath.sv
`default_nettype none

module hkta_datapath
	import hkta_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire hkta_cmd_t  cmd,
	input  wire logic [7:0] modifiers,
	input  wire logic [7:0] key_code,
	output logic            read_valid,
	output logic [6:0]      read_char,
	output logic            data_available,
	output logic            key_unmapped,
	output logic            queue_overflow
);

	ptr_t  wr_q, rd_q;
	ptr_t  wr_next, rd_next;
	char_t key_char;
	char_t ram_rdata;
	logic  nonempty, full, push;
	logic  read_valid_q, avail_q, unmapped_q, overflow_q;
	char_t read_char_q;

	assign key_char = apply_shift(modifiers, layout_lookup(key_code));
	assign wr_next  = next_ptr(wr_q);
	assign rd_next  = next_ptr(rd_q);
	assign nonempty = (rd_q != wr_q);
	assign full     = (wr_next == rd_q);
	assign push     = cmd.start_key && (key_char != '0) && !full;

	hkta_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wr_q),
		.wdata(key_char),
		.re   (cmd.start_read && nonempty),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_next;
			end
			if (cmd.start_read && nonempty) begin
				rd_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_key) begin
			read_valid_q <= 1'b0;
			read_char_q  <= '0;
			unmapped_q   <= (key_char == '0);
			overflow_q   <= (key_char != '0) && full;
			avail_q      <= push || nonempty;
		end else if (cmd.start_read) begin
			read_valid_q <= nonempty;
			read_char_q  <= '0;
			unmapped_q   <= 1'b0;
			overflow_q   <= 1'b0;
			avail_q      <= nonempty && (rd_next != wr_q);
		end else if (cmd.finish_read) begin
			read_char_q <= read_valid_q ? ram_rdata : '0;
		end
	end

	assign read_valid     = read_valid_q;
	assign read_char      = read_char_q;
	assign data_available = avail_q;
	assign key_unmapped   = unmapped_q;
	assign queue_overflow = overflow_q;

endmodule

`default_nettype wire

### hdl/hid_keycode_to_ascii_fifo_core.sv
`default_nettype none

// Keyboard event translator with a character queue. Each request transfer is
// either a key event (operation 0: a HID modifier byte and a usage code) or a
// read (operation 1). A key event is mapped through a German-layout table,
// with either shift key turning letters to upper case and minus to
// underscore; a nonzero character goes into a ring buffer of DEPTH slots
// that holds at most DEPTH-1 characters. A read pops the oldest character.
// Every request produces exactly one response transfer. The response flags
// a successful read (read_valid with read_char), a key whose code has no
// character (key_unmapped), a character dropped because the buffer was full
// (queue_overflow), and whether the buffer still holds data afterwards
// (data_available). Reading an empty buffer returns read_valid low and a zero
// character without blocking. Timing: a key event is answered in the cycle
// after its transfer, and with the response taken at once a new key event can
// be accepted every cycle. A read also passes the READ state, as the character
// buffer is a memory with a registered read port. The response is held in
// output registers, and the next request is accepted in the same cycle that
// the pending response is transferred. No clearing pass is needed after
// reset: the buffer pointers reset to empty and only written slots are read.
module hid_keycode_to_ascii_fifo_core
	import hkta_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic       operation,
	input  wire logic [7:0] modifiers,
	input  wire logic [7:0] key_code,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic            read_valid,
	output logic [6:0]      read_char,
	output logic            data_available,
	output logic            key_unmapped,
	output logic            queue_overflow
);

	hkta_cmd_t cmd;

	// The controller sequences the handshakes and the read through its READ state.
	hkta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.operation(operation),
		.rsp_ready(rsp_ready),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.cmd      (cmd)
	);

	// The datapath holds the translation logic, the buffer pointers, the
	// character memory and the response registers.
	hkta_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.modifiers     (modifiers),
		.key_code      (key_code),
		.read_valid    (read_valid),
		.read_char     (read_char),
		.data_available(data_available),
		.key_unmapped  (key_unmapped),
		.queue_overflow(queue_overflow)
	);

	// A new request must never be taken while a response is held but not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && rsp_valid) |-> rsp_ready)
		else $error("request accepted over a pending response");

	// A key result can not be both unmapped and dropped.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(key_unmapped && queue_overflow))
		else $error("unmapped and overflow flagged together");

	// A dropped character means the buffer is full, so data remains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && queue_overflow) |-> data_available)
		else $error("overflow reported with an empty buffer");

	// Without a popped character the returned character is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !read_valid) |-> (read_char == '0))
		else $error("character returned without a successful read");

endmodule

`default_nettype wire
